// ----- hw/rtl/nzda_pkg.sv -----
// Package for the ZDA sentence parser: status and field codes, parser state
// and result structs, and small character helpers. No dependencies.
package nzda_pkg;

	typedef enum logic [3:0] {
		ST_OK_CK       = 4'd0,
		ST_OK_NOCK     = 4'd1,
		ST_NOT_ZDA     = 4'd2,
		ST_NO_FIX      = 4'd3,
		ST_EXTRA_COMMA = 4'd4,
		ST_TRAIL_COMMA = 4'd5,
		ST_BAD_STAR    = 4'd6,
		ST_NO_FIRST    = 4'd7,
		ST_BAD_CHAR    = 4'd8,
		ST_TRUNC       = 4'd9,
		ST_BAD_TIME    = 4'd10,
		ST_BAD_MONTH   = 4'd11,
		ST_BAD_DAY     = 4'd12,
		ST_BAD_TZ      = 4'd13,
		ST_BAD_MZ      = 4'd14,
		ST_BAD_CK      = 4'd15
	} status_t;

	typedef enum logic [2:0] {
		F_NONE  = 3'd0,
		F_TIME  = 3'd1,
		F_DAY   = 3'd2,
		F_MONTH = 3'd3,
		F_YEAR  = 3'd4,
		F_TZ    = 3'd5,
		F_MZ    = 3'd6,
		F_CK    = 3'd7
	} field_t;

	localparam logic [2:0] PREFIX_LEN = 3'd6;
	localparam int TDATA_W = 88;

	typedef struct packed {
		logic [2:0]         prefix_pos;
		field_t             field;
		logic [3:0]         digit_count;
		logic [13:0]        acc;
		logic               neg;
		status_t            status;
		logic               err;
		logic               time_seen;
		logic [1:0]         ck_nib;
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic [9:0]         millisecond;
		logic [6:0]         day;
		logic [6:0]         month;
		logic [13:0]        year;
		logic signed [7:0]  zone_hours;
		logic signed [7:0]  zone_minutes;
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic [9:0]         millisecond;
		logic [6:0]         day;
		logic [6:0]         month;
		logic [13:0]        year;
		logic signed [7:0]  zone_hours;
		logic signed [7:0]  zone_minutes;
		logic [7:0]         checksum_value;
	} result_t;

	localparam state_t STATE_RESET = '{
		prefix_pos: 3'd0, field: F_NONE, digit_count: 4'd0, acc: 14'd0, neg: 1'b0,
		status: ST_OK_CK, err: 1'b0, time_seen: 1'b0, ck_nib: 2'd0,
		hour: 7'd0, minute: 7'd0, second: 7'd0, millisecond: 10'd0,
		day: 7'd0, month: 7'd0, year: 14'd0, zone_hours: 8'sd0, zone_minutes: 8'sd0
	};

	function automatic logic [7:0] head_char(input logic [2:0] pos);
		case (pos)
			3'd0:    head_char = "$";
			3'd1:    head_char = "G";
			3'd2:    head_char = "P";
			3'd3:    head_char = "Z";
			3'd4:    head_char = "D";
			3'd5:    head_char = "A";
			default: head_char = 8'h00;
		endcase
	endfunction

	function automatic logic [3:0] field_digits(input field_t f);
		case (f)
			F_TIME:  field_digits = 4'd10;
			F_DAY:   field_digits = 4'd2;
			F_MONTH: field_digits = 4'd2;
			F_YEAR:  field_digits = 4'd4;
			F_TZ:    field_digits = 4'd2;
			F_MZ:    field_digits = 4'd2;
			default: field_digits = 4'd0;
		endcase
	endfunction

	// {valid, nibble} for upper-case hex digits
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c inside {["0":"9"]}) begin
			t = c - 8'h30;
			hex_val = {1'b1, t[3:0]};
		end else if (c inside {["A":"F"]}) begin
			t = c - 8'h37;
			hex_val = {1'b1, t[3:0]};
		end else begin
			hex_val = 5'd0;
		end
	endfunction

endpackage

// ----- hw/rtl/nzda_step.sv -----
// One character step of the ZDA parser: next parser state and the result
// that a final character would give. Pure logic; uses nzda_pkg.
module nzda_step
	import nzda_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] ch,
	output state_t     nxt,
	output result_t    res
);

	logic        done;
	logic        partial;
	logic [4:0]  hx;
	logic [13:0] acc_dig;
	logic [3:0]  dc_inc;
	logic [7:0]  mag8;
	logic        is_digit;

	assign hx       = hex_val(ch);
	assign is_digit = ch inside {["0":"9"]};
	assign acc_dig  = {cur.acc[10:0], 3'b000} + {cur.acc[12:0], 1'b0} + {10'd0, ch[3:0]};
	assign dc_inc   = cur.digit_count + 4'd1;
	assign mag8     = acc_dig[7:0];
	assign done     = (cur.field != F_NONE) && (cur.field != F_CK)
		&& (cur.digit_count == field_digits(cur.field));
	assign partial  = (cur.field != F_NONE) && (cur.field != F_CK) && !done
		&& ((cur.digit_count != 4'd0) || cur.neg);

	always_comb begin
		nxt = cur;
		if (!cur.err) begin
			if (cur.prefix_pos < PREFIX_LEN) begin
				if (ch == head_char(cur.prefix_pos)) begin
					nxt.prefix_pos = cur.prefix_pos + 3'd1;
				end else begin
					nxt.err = 1'b1; nxt.status = ST_NOT_ZDA;
				end
			end else if (cur.field == F_CK && cur.ck_nib != 2'd0) begin
				// second hex digit; anything after that is ignored
				if (cur.ck_nib == 2'd1) begin
					if (!hx[4]) begin
						nxt.err = 1'b1; nxt.status = ST_BAD_CK;
					end else begin
						nxt.acc = {cur.acc[9:0], hx[3:0]};
						nxt.ck_nib = 2'd2;
					end
				end
			end else if (ch == "," || ch == "*") begin
				if (partial) begin
					nxt.err = 1'b1;
					nxt.status = (cur.field == F_TIME && cur.digit_count == 4'd6)
						? ST_BAD_TIME : ST_BAD_CHAR;
				end else if (ch == ",") begin
					if (cur.field == F_MZ) begin
						nxt.err = 1'b1; nxt.status = ST_EXTRA_COMMA;
					end else if (cur.field == F_CK) begin
						nxt.err = 1'b1; nxt.status = ST_TRAIL_COMMA;
					end else begin
						nxt.field = field_t'(cur.field + 3'd1);
						nxt.digit_count = 4'd0; nxt.acc = 14'd0; nxt.neg = 1'b0;
					end
				end else begin
					if (cur.field != F_MZ) begin
						nxt.err = 1'b1; nxt.status = ST_BAD_STAR;
					end else begin
						nxt.field = F_CK;
						nxt.digit_count = 4'd0; nxt.acc = 14'd0; nxt.neg = 1'b0;
					end
				end
			end else if (cur.field == F_NONE) begin
				nxt.err = 1'b1; nxt.status = ST_NO_FIRST;
			end else if (cur.field == F_CK) begin
				if (!cur.time_seen) begin
					nxt.err = 1'b1; nxt.status = ST_NO_FIX;
				end else if (!hx[4]) begin
					nxt.err = 1'b1; nxt.status = ST_BAD_CK;
				end else begin
					nxt.acc = {10'd0, hx[3:0]};
					nxt.ck_nib = 2'd1;
				end
			end else if (done) begin
				nxt.err = 1'b1; nxt.status = ST_BAD_CHAR;
			end else if (cur.field == F_TIME && cur.digit_count == 4'd6) begin
				if (ch == ".") begin
					nxt.digit_count = 4'd7;
				end else begin
					nxt.err = 1'b1; nxt.status = ST_BAD_TIME;
				end
			end else if (ch == "-" && (cur.field == F_TZ || cur.field == F_MZ)
				&& cur.digit_count == 4'd0 && !cur.neg) begin
				nxt.neg = 1'b1;
			end else if (is_digit) begin
				nxt.acc = acc_dig;
				nxt.digit_count = dc_inc;
				if (cur.field == F_TIME) begin
					case (dc_inc)
						4'd2: begin
							nxt.hour = acc_dig[6:0]; nxt.acc = 14'd0;
						end
						4'd4: begin
							nxt.minute = acc_dig[6:0]; nxt.acc = 14'd0;
						end
						4'd6: begin
							nxt.second = acc_dig[6:0]; nxt.acc = 14'd0;
						end
						4'd10: begin
							nxt.millisecond = acc_dig[9:0]; nxt.acc = 14'd0;
							nxt.time_seen = 1'b1;
						end
						default: ;
					endcase
				end else if (dc_inc == field_digits(cur.field)) begin
					case (cur.field)
						F_DAY: begin
							nxt.day = acc_dig[6:0];
							if (acc_dig > 14'd31) begin
								nxt.err = 1'b1; nxt.status = ST_BAD_DAY;
							end
						end
						F_MONTH: begin
							nxt.month = acc_dig[6:0];
							if (acc_dig > 14'd12) begin
								nxt.err = 1'b1; nxt.status = ST_BAD_MONTH;
							end
						end
						F_YEAR: nxt.year = acc_dig;
						F_TZ: begin
							nxt.zone_hours = cur.neg ? -mag8 : mag8;
							if (acc_dig > 14'd13) begin
								nxt.err = 1'b1; nxt.status = ST_BAD_TZ;
							end
						end
						F_MZ: begin
							nxt.zone_minutes = cur.neg ? -mag8 : mag8;
							if (acc_dig > 14'd60) begin
								nxt.err = 1'b1; nxt.status = ST_BAD_MZ;
							end
						end
						default: ;
					endcase
				end
			end else begin
				nxt.err = 1'b1; nxt.status = ST_BAD_CHAR;
			end
		end
	end

	always_comb begin
		res.hour = nxt.hour;
		res.minute = nxt.minute;
		res.second = nxt.second;
		res.millisecond = nxt.millisecond;
		res.day = nxt.day;
		res.month = nxt.month;
		res.year = nxt.year;
		res.zone_hours = nxt.zone_hours;
		res.zone_minutes = nxt.zone_minutes;
		res.checksum_value = 8'd0;
		if (nxt.err) begin
			res.status = nxt.status;
		end else if (nxt.prefix_pos < PREFIX_LEN) begin
			res.status = ST_NOT_ZDA;
		end else if (nxt.field == F_CK) begin
			if (!nxt.time_seen) begin
				res.status = ST_NO_FIX;
			end else if (nxt.ck_nib == 2'd2) begin
				res.status = ST_OK_CK;
				res.checksum_value = nxt.acc[7:0];
			end else begin
				res.status = ST_OK_NOCK;
			end
		end else begin
			res.status = ST_TRUNC;
		end
	end

endmodule

// ----- hw/rtl/nmea_zda_sentence_parser.sv -----
// Top level of the ZDA sentence parser: input register, parser state,
// result register and stream handshakes. Uses nzda_pkg and nzda_step.
//
//   channel | dir | payload
//   s_*     | in  | tdata[7:0] char_in, tlast is_last
//   m_*     | out | tuser[3:0] status, tdata hour..checksum_value
//
// One character per cycle while no stall on m_* holds a final character;
// a result passes the input register, then the result register.
// The parser state advances in the cycle the registered character is used.
// Reset clears the parser state and both valid flags.
// A stall on m_* holds only a final character in the input register;
// other characters keep flowing while a result waits.
module nmea_zda_sentence_parser
	import nzda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] char_in
	input  logic               s_tlast,   // is_last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // hour, minute, second, millisecond, day, month,
	                                      // year, zone_hours, zone_minutes, checksum_value
	output logic [3:0]         m_tuser    // [3:0] status
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	result_t    res_q;
	logic       m_valid_q;
	logic       out_free;
	logic       take_s1;

	assign out_free = !m_valid_q || m_tready;
	assign take_s1  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nzda_step u_step (
		.cur (state_q),
		.ch  (char_s1),
		.nxt (state_nxt),
		.res (res)
	);

	// a final character sends the parser back to its reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (take_s1) begin
			state_q <= last_s1 ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {5'd0, res_q.checksum_value, res_q.zone_minutes, res_q.zone_hours,
		res_q.year, res_q.month, res_q.day, res_q.millisecond,
		res_q.second, res_q.minute, res_q.hour};

`ifndef ASSERT_OFF
	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a final character");

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && last_s1) |=> (state_q.prefix_pos == 3'd0 && !state_q.err
			&& state_q.field == F_NONE))
		else $error("parser state not cleared after final character");

	a_ck_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK_CK) |-> (m_tdata[82:75] == 8'd0))
		else $error("checksum value reported without ok_checksum");
`endif

endmodule

// ----- tb/nmea_zda_sentence_parser_tb.sv -----
// Self-checking testbench for nmea_zda_sentence_parser: feeds ZDA lines one
// character per item, predicts each line's result and checks it field by field.
// Depends on nzda_pkg for the status and field codes and the result layout.
module nmea_zda_sentence_parser_tb;
	import nzda_pkg::*;

	localparam int SLOT_HOUR  = 0;
	localparam int SLOT_MIN   = 1;
	localparam int SLOT_SEC   = 2;
	localparam int SLOT_MS    = 3;
	localparam int SLOT_DAY   = 4;
	localparam int SLOT_MONTH = 5;
	localparam int SLOT_YEAR  = 6;
	localparam int SLOT_TZ    = 7;
	localparam int SLOT_MZ    = 8;
	localparam int TAG_LEN    = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct {
		logic [7:0]  ch;
		logic        last;
		int unsigned gap;
	} char_item_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'd0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [3:0]          m_tuser;

	logic [7:0] zda_tag [TAG_LEN] = '{"$", "G", "P", "Z", "D", "A"};

	// predictor state
	logic [2:0]  hdr_pos;
	field_t      cur_field;
	logic [3:0]  ndig;
	logic [13:0] acc;
	logic        neg;
	status_t     first_err;
	logic        err_latched;
	logic        fix_seen;
	logic [1:0]  ck_nibs;
	logic [13:0] parsed [9];

	char_item_t  pending_chars[$];
	result_t     expected_fixes[$];
	logic [7:0]  line_buf[$];
	char_item_t  nxt;

	int          n_fail = 0;
	int          n_lines = 0;
	int          n_chars = 0;
	int          n_results = 0;
	logic [15:0] status_mask = 16'd0;
	bit          took = 1'b0;
	bit          gap_loaded = 1'b0;
	int unsigned gap_left = 0;
	int unsigned rx_stall = 0;
	bit          pressure_hold = 1'b0;

	nmea_zda_sentence_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------- predictor ----------------

	function automatic logic [3:0] digits_in(field_t f);
		case (f)
			F_TIME:  return 4'd10;
			F_YEAR:  return 4'd4;
			F_DAY, F_MONTH, F_TZ, F_MZ: return 4'd2;
			default: return 4'd0;
		endcase
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic void clear_parser();
		hdr_pos = 3'd0;
		cur_field = F_NONE;
		ndig = 4'd0;
		acc = 14'd0;
		neg = 1'b0;
		first_err = ST_OK_CK;
		err_latched = 1'b0;
		fix_seen = 1'b0;
		ck_nibs = 2'd0;
		for (int i = 0; i < 9; i++) parsed[i] = 14'd0;
	endfunction

	function automatic void flag_error(status_t s);
		if (!err_latched) begin
			first_err = s;
			err_latched = 1'b1;
		end
	endfunction

	function automatic void store_zone(int slot, int limit, status_t code);
		parsed[slot] = neg ? 14'(-int'(acc)) : acc;
		if (int'(acc) > limit) flag_error(code);
	endfunction

	function automatic void take_digit(int d);
		acc = 14'(int'(acc) * 10 + d);
		ndig = ndig + 4'd1;
		if (cur_field == F_TIME) begin
			// hh mm ss split off as they complete; the fraction ends the field
			case (ndig)
				4'd2: begin parsed[SLOT_HOUR] = acc; acc = 14'd0; end
				4'd4: begin parsed[SLOT_MIN] = acc; acc = 14'd0; end
				4'd6: begin parsed[SLOT_SEC] = acc; acc = 14'd0; end
				4'd10: begin
					parsed[SLOT_MS] = acc;
					acc = 14'd0;
					fix_seen = 1'b1;
				end
				default: ;
			endcase
			return;
		end
		if (ndig != digits_in(cur_field)) return;
		case (cur_field)
			F_DAY: begin
				parsed[SLOT_DAY] = acc;
				if (acc > 14'd31) flag_error(ST_BAD_DAY);
			end
			F_MONTH: begin
				parsed[SLOT_MONTH] = acc;
				if (acc > 14'd12) flag_error(ST_BAD_MONTH);
			end
			F_YEAR: parsed[SLOT_YEAR] = acc;
			F_TZ:   store_zone(SLOT_TZ, 13, ST_BAD_TZ);
			F_MZ:   store_zone(SLOT_MZ, 60, ST_BAD_MZ);
			default: ;
		endcase
	endfunction

	function automatic void parse_char(logic [7:0] c);
		bit full;
		bit part;
		int h;
		if (hdr_pos < TAG_LEN) begin
			if (c == zda_tag[hdr_pos]) hdr_pos = hdr_pos + 3'd1;
			else flag_error(ST_NOT_ZDA);
			return;
		end
		if (cur_field == F_CK && ck_nibs != 2'd0) begin
			// second hex digit; anything after it is ignored
			if (ck_nibs == 2'd1) begin
				h = hex_nibble(c);
				if (h < 0) begin
					flag_error(ST_BAD_CK);
					return;
				end
				acc = {acc[9:0], h[3:0]};
				ck_nibs = 2'd2;
			end
			return;
		end
		full = cur_field != F_NONE && cur_field != F_CK && ndig == digits_in(cur_field);
		part = cur_field != F_NONE && cur_field != F_CK && !full && (ndig != 0 || neg);
		if (c == "," || c == "*") begin
			if (part) begin
				flag_error((cur_field == F_TIME && ndig == 4'd6) ? ST_BAD_TIME : ST_BAD_CHAR);
				return;
			end
			if (c == ",") begin
				if (cur_field == F_MZ) begin
					flag_error(ST_EXTRA_COMMA);
					return;
				end
				if (cur_field == F_CK) begin
					flag_error(ST_TRAIL_COMMA);
					return;
				end
				cur_field = field_t'(cur_field + 3'd1);
			end else begin
				if (cur_field != F_MZ) begin
					flag_error(ST_BAD_STAR);
					return;
				end
				cur_field = F_CK;
			end
			ndig = 4'd0;
			acc = 14'd0;
			neg = 1'b0;
			return;
		end
		if (cur_field == F_NONE) begin
			flag_error(ST_NO_FIRST);
			return;
		end
		if (cur_field == F_CK) begin
			if (!fix_seen) begin
				flag_error(ST_NO_FIX);
				return;
			end
			h = hex_nibble(c);
			if (h < 0) begin
				flag_error(ST_BAD_CK);
				return;
			end
			acc = 14'(h);
			ck_nibs = 2'd1;
			return;
		end
		if (full) begin
			flag_error(ST_BAD_CHAR);
			return;
		end
		if (cur_field == F_TIME && ndig == 4'd6) begin
			if (c == ".") ndig = 4'd7;
			else flag_error(ST_BAD_TIME);
			return;
		end
		if (c == "-" && (cur_field == F_TZ || cur_field == F_MZ) && ndig == 0 && !neg) begin
			neg = 1'b1;
			return;
		end
		if (c >= "0" && c <= "9") take_digit(int'(c - "0"));
		else flag_error(ST_BAD_CHAR);
	endfunction

	function automatic void advance_parser(logic [7:0] c, logic last);
		result_t fix;
		status_t st;
		if (!err_latched) parse_char(c);
		if (!last) return;
		fix.checksum_value = 8'd0;
		if (err_latched) st = first_err;
		else if (hdr_pos < TAG_LEN) st = ST_NOT_ZDA;
		else if (cur_field == F_CK) begin
			if (!fix_seen) st = ST_NO_FIX;
			else if (ck_nibs == 2'd2) begin
				st = ST_OK_CK;
				fix.checksum_value = acc[7:0];
			end else st = ST_OK_NOCK;
		end else st = ST_TRUNC;
		fix.status = st;
		fix.hour = parsed[SLOT_HOUR][6:0];
		fix.minute = parsed[SLOT_MIN][6:0];
		fix.second = parsed[SLOT_SEC][6:0];
		fix.millisecond = parsed[SLOT_MS][9:0];
		fix.day = parsed[SLOT_DAY][6:0];
		fix.month = parsed[SLOT_MONTH][6:0];
		fix.year = parsed[SLOT_YEAR];
		fix.zone_hours = parsed[SLOT_TZ][7:0];
		fix.zone_minutes = parsed[SLOT_MZ][7:0];
		expected_fixes.push_back(fix);
		clear_parser();
	endfunction

	// ---------------- checking ----------------

	function automatic void check_field(string nm, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
			n_fail++;
		end
	endfunction

	function automatic void check_fix();
		result_t want;
		if (expected_fixes.size() == 0) begin
			$display("%0t: result with none expected, status %0d", $time, m_tuser);
			n_fail++;
			return;
		end
		want = expected_fixes.pop_front();
		check_field("status", int'(want.status), int'(m_tuser));
		check_field("hour", int'(want.hour), int'(m_tdata[6:0]));
		check_field("minute", int'(want.minute), int'(m_tdata[13:7]));
		check_field("second", int'(want.second), int'(m_tdata[20:14]));
		check_field("millisecond", int'(want.millisecond), int'(m_tdata[30:21]));
		check_field("day", int'(want.day), int'(m_tdata[37:31]));
		check_field("month", int'(want.month), int'(m_tdata[44:38]));
		check_field("year", int'(want.year), int'(m_tdata[58:45]));
		check_field("zone_hours", int'(want.zone_hours), int'($signed(m_tdata[66:59])));
		check_field("zone_minutes", int'(want.zone_minutes), int'($signed(m_tdata[74:67])));
		check_field("checksum_value", int'(want.checksum_value), int'(m_tdata[82:75]));
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			advance_parser(s_tdata, s_tlast);
			took = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			check_fix();
			status_mask[m_tuser] = 1'b1;
			n_results++;
		end
	end

	// ---------------- driving ----------------

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || took)) begin
			if (pending_chars.size() != 0 && !gap_loaded) begin
				gap_left = pending_chars[0].gap;
				gap_loaded = 1'b1;
			end
			if (pending_chars.size() != 0 && gap_left == 0) begin
				nxt = pending_chars.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.ch;
				s_tlast <= nxt.last;
				gap_loaded = 1'b0;
			end else begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
		took = 1'b0;
	end

	always @(negedge clk) begin
		if (pressure_hold) begin
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 20) rx_stall = idle_len();
		end
	end

	// long receiver hold-off: the final character of the next line backs up
	initial begin
		while (n_results < 12) @(posedge clk);
		pressure_hold = 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		pressure_hold = 1'b0;
	end

	// ---------------- line generation ----------------

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void put_digits(int n, int val);
		int scale;
		scale = 1;
		for (int i = 1; i < n; i++) scale *= 10;
		for (int i = 0; i < n; i++) begin
			line_buf.push_back(8'h30 + 8'((val / scale) % 10));
			scale /= 10;
		end
	endfunction

	function automatic logic [7:0] hex_char(int v);
		return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
	endfunction

	// numeric field: usually in range and exact length, sometimes empty,
	// out of range or of the wrong length
	function automatic void put_num_field(int n, int hi_typ, int hi_max, bit signed_ok);
		int r;
		int v;
		r = $urandom_range(0, 19);
		if (r == 0) return;
		if (signed_ok && $urandom_range(0, 2) == 0) line_buf.push_back("-");
		v = (r == 1) ? $urandom_range(0, hi_max) : $urandom_range(0, hi_typ);
		put_digits((r == 2) ? $urandom_range(1, n + 1) : n, v);
	endfunction

	function automatic void push_line();
		char_item_t it;
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		foreach (line_buf[i]) begin
			it.ch = line_buf[i];
			it.last = (i == line_buf.size() - 1);
			it.gap = steady ? 0 : idle_len();
			pending_chars.push_back(it);
			n_chars++;
		end
		n_lines++;
	endfunction

	function automatic void queue_text(string s);
		line_buf.delete();
		put_str(s);
		push_line();
	endfunction

	function automatic void queue_random_line();
		int r;
		int len;
		string marks;
		marks = ",*-.0a";
		line_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			// noise: raw bytes, sometimes behind part of the tag
			if ($urandom_range(0, 1) == 0) put_str("$GPZ");
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
			push_line();
			return;
		end
		put_str("$GPZDA,");
		r = $urandom_range(0, 11);
		if (r != 0) begin
			put_digits(2, $urandom_range(0, 99));
			put_digits(2, $urandom_range(0, 99));
			put_digits(2, $urandom_range(0, 99));
			if (r != 1) begin
				line_buf.push_back(".");
				put_digits(3, $urandom_range(0, 999));
			end
		end
		line_buf.push_back(",");
		put_num_field(2, 31, 99, 1'b0);
		line_buf.push_back(",");
		put_num_field(2, 12, 99, 1'b0);
		line_buf.push_back(",");
		put_num_field(4, 9999, 9999, 1'b0);
		line_buf.push_back(",");
		put_num_field(2, 13, 99, 1'b1);
		line_buf.push_back(",");
		put_num_field(2, 60, 99, 1'b1);
		line_buf.push_back("*");
		r = $urandom_range(0, 9);
		if (r >= 1) line_buf.push_back(hex_char($urandom_range(0, 15)));
		if (r >= 3) line_buf.push_back(hex_char($urandom_range(0, 15)));
		if (r == 9) put_str("\r\n");
		// occasional damage to an otherwise good line
		len = line_buf.size();
		case ($urandom_range(0, 11))
			0: line_buf[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
			1: while (line_buf.size() > $urandom_range(1, len)) void'(line_buf.pop_back());
			2: line_buf.insert($urandom_range(0, len - 1), marks[$urandom_range(0, 5)]);
			3: line_buf.delete($urandom_range(0, len - 1));
			default: ;
		endcase
		push_line();
	endfunction

	// ---------------- stimulus and end of run ----------------

	initial begin
		clear_parser();
		queue_text("$GPZDA,235959.999,31,12,9999,-13,-60*FF");
		queue_text("$GPZDA,000000.000,00,00,0000,13,60*0");
		queue_text("$GP");
		queue_text("$GPZDA*");
		queue_text("$GPZDAX");
		queue_text("$GPZDA,12");
		queue_text("$GPZDA,,,,,,*");
		queue_text("$GPZDA,,,,,,*1");
		queue_text("$GPZDA,,,,,,,");
		queue_text("$GPZDA,120000.000,,,,,*,");
		queue_text("$GPZDA,120000.000,,,,,**");
		queue_text("$GPZDA,120000.000,,,,,*1g");
		queue_text("$GPZDA,1200001");
		queue_text("$GPZDA,120000,");
		queue_text("$GPZDA,1200.00");
		queue_text("$GPZDA,120000.000,32,13,2024,14,-61*");
		queue_text("$GPZDA,120000.000,,13,,,*");
		queue_text("$GPZDA,120000.000,,,,-14,*");
		queue_text("$GPZDA,120000.000,,,,,-61*");
		queue_text("$GPZDA,120000.000,011");
		queue_text("$GPZDA,120000.000,,,,1-");
		queue_text("$GPZDA,120000.000,,,,-,");
		queue_text("$GPZDA,120000.000,-1");
		queue_text("$GPZDA,120000.000,,,,,*AB$x");
		while (n_chars < 1800 || n_lines < 60) queue_random_line();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d lines of %0d characters sent, %0d results checked, %0d of 16 status codes seen",
			n_lines, n_chars, n_results, $countones(status_mask));
		if (n_fail == 0) begin
			$display("nmea_zda_sentence_parser verification clean");
		end else begin
			$display("nmea_zda_sentence_parser verification failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t: timeout, %0d results still expected", $time, expected_fixes.size());
		$display("nmea_zda_sentence_parser verification failed");
		$finish;
	end

endmodule

// ----- nmea_zda_sentence_parser.f -----
hw/rtl/nzda_pkg.sv
hw/rtl/nzda_step.sv
hw/rtl/nmea_zda_sentence_parser.sv
tb/nmea_zda_sentence_parser_tb.sv
